// ===== rtl/gregorian_date_arithmetic_unit_defines.svh =====
// -----------------------------------------------------------------------------
// Gregorian date arithmetic unit: assertion macros
// Shared property wrappers; clocked on clk, quiet while arst_n is low.
// -----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ARITHMETIC_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define GDA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GDA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gda_pkg.sv =====
// -----------------------------------------------------------------------------
// gda_pkg
// Types, constants and calendar tables of the Gregorian date arithmetic unit.
// -----------------------------------------------------------------------------
package gda_pkg;

	localparam int unsigned MAX_YEAR = 9999;
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MON_W    = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned OFF_W    = 21;
	localparam int unsigned DIFF_W   = 23;
	localparam int unsigned SER_W    = 23;
	localparam int unsigned SUM_W    = SER_W + 2;
	localparam int unsigned BIT_W    = $clog2(YEAR_W);
	localparam int unsigned REM_W    = 9;
	localparam int unsigned CUM_W    = 9;
	localparam int unsigned MONTHS   = 12;

	// floor(p / 100) = (p * 5243) >> 19, exact for p below 43699
	localparam int unsigned RECIP_100 = 5243;
	localparam int unsigned RECIP_W   = 13;
	localparam int unsigned RECIP_SH  = 19;
	localparam int unsigned Q_W       = 8;

	// last day number of MAX_YEAR (day 0 is 0001-01-01)
	localparam int unsigned SER_TOP = MAX_YEAR * 365 + MAX_YEAR / 4
		- MAX_YEAR / 100 + MAX_YEAR / 400 - 1;

	typedef enum logic [1:0] {
		MODE_SET  = 2'd0,
		MODE_ADD  = 2'd1,
		MODE_CMP  = 2'd2,
		MODE_DIFF = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REL_LESS    = 2'd0,
		REL_EQUAL   = 2'd1,
		REL_GREATER = 2'd2
	} rel_t;

	typedef enum logic [3:0] {
		OP_NONE   = 4'd0,
		OP_LOAD   = 4'd1,
		OP_SER_A  = 4'd2,
		OP_SER_B  = 4'd3,
		OP_SET    = 4'd4,
		OP_SAVE   = 4'd5,
		OP_SUM    = 4'd6,
		OP_DIFF   = 4'd7,
		OP_SRCH   = 4'd8,
		OP_JAN    = 4'd9,
		OP_WALK   = 4'd10,
		OP_RESULT = 4'd11
	} dp_op_t;

	typedef enum logic [1:0] {
		SRC_GIVEN = 2'd0,
		SRC_CUR   = 2'd1,
		SRC_CAND  = 2'd2,
		SRC_YEAR  = 2'd3
	} src_t;

	typedef struct packed {
		dp_op_t op;
		src_t   src;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  sum_ok;
		logic  bit_zero;
		logic  walk_done;
		logic  out_free;
	} dp_stat_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// days of the year before the first of month m
	function automatic logic [CUM_W-1:0] days_before(input logic [MON_W-1:0] m,
		input logic leap);
		logic [CUM_W-1:0] cum;
		case (m)
			4'd1:    cum = 9'd0;
			4'd2:    cum = 9'd31;
			4'd3:    cum = 9'd59;
			4'd4:    cum = 9'd90;
			4'd5:    cum = 9'd120;
			4'd6:    cum = 9'd151;
			4'd7:    cum = 9'd181;
			4'd8:    cum = 9'd212;
			4'd9:    cum = 9'd243;
			4'd10:   cum = 9'd273;
			4'd11:   cum = 9'd304;
			4'd12:   cum = 9'd334;
			default: cum = 9'd0;
		endcase
		if (leap && (m > 4'd2)) begin
			cum = cum + 9'd1;
		end
		return cum;
	endfunction

endpackage

// ===== rtl/gda_ctrl.sv =====
// -----------------------------------------------------------------------------
// gda_ctrl
// Sequencer: steps the datapath through set, add, compare and difference.
// -----------------------------------------------------------------------------
module gda_ctrl import gda_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic [1:0] item_mode,
	output logic       item_ready,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd
);

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_G_A    = 17'h00002,
		S_G_B    = 17'h00004,
		S_SET    = 17'h00008,
		S_SAVE   = 17'h00010,
		S_C_A    = 17'h00020,
		S_C_B    = 17'h00040,
		S_SUM    = 17'h00080,
		S_DIFF   = 17'h00100,
		S_K_A    = 17'h00200,
		S_K_B    = 17'h00400,
		S_K_STEP = 17'h00800,
		S_Y_A    = 17'h01000,
		S_Y_B    = 17'h02000,
		S_JAN    = 17'h04000,
		S_WALK   = 17'h08000,
		S_DONE   = 17'h10000
	} state_t;

	state_t state_q, state_d;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		cmd.src = SRC_GIVEN;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.op = OP_LOAD;
					case (mode_t'(item_mode))
						MODE_SET:  state_d = S_G_A;
						MODE_ADD:  state_d = S_C_A;
						MODE_CMP:  state_d = S_DONE;
						MODE_DIFF: state_d = S_G_A;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_G_A: begin
				cmd.op  = OP_SER_A;
				cmd.src = SRC_GIVEN;
				state_d = S_G_B;
			end
			S_G_B: begin
				cmd.op  = OP_SER_B;
				state_d = (stat.mode == MODE_SET) ? S_SET : S_SAVE;
			end
			S_SET: begin
				cmd.op  = OP_SET;
				state_d = S_DONE;
			end
			S_SAVE: begin
				cmd.op  = OP_SAVE;
				state_d = S_C_A;
			end
			S_C_A: begin
				cmd.op  = OP_SER_A;
				cmd.src = SRC_CUR;
				state_d = S_C_B;
			end
			S_C_B: begin
				cmd.op  = OP_SER_B;
				state_d = (stat.mode == MODE_ADD) ? S_SUM : S_DIFF;
			end
			S_SUM: begin
				cmd.op  = OP_SUM;
				state_d = stat.sum_ok ? S_K_A : S_DONE;
			end
			S_DIFF: begin
				cmd.op  = OP_DIFF;
				state_d = S_DONE;
			end
			S_K_A: begin
				cmd.op  = OP_SER_A;
				cmd.src = SRC_CAND;
				state_d = S_K_B;
			end
			S_K_B: begin
				cmd.op  = OP_SER_B;
				state_d = S_K_STEP;
			end
			S_K_STEP: begin
				cmd.op  = OP_SRCH;
				state_d = stat.bit_zero ? S_Y_A : S_K_A;
			end
			S_Y_A: begin
				cmd.op  = OP_SER_A;
				cmd.src = SRC_YEAR;
				state_d = S_Y_B;
			end
			S_Y_B: begin
				cmd.op  = OP_SER_B;
				state_d = S_JAN;
			end
			S_JAN: begin
				cmd.op  = OP_JAN;
				state_d = S_WALK;
			end
			S_WALK: begin
				cmd.op = OP_WALK;
				if (stat.walk_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.op = OP_RESULT;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/gda_dpath.sv =====
// -----------------------------------------------------------------------------
// gda_dpath
// Date registers, shared day-number unit, year search and month walk.
// -----------------------------------------------------------------------------
`include "gregorian_date_arithmetic_unit_defines.svh"

module gda_dpath import gda_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	input  logic [1:0]               in_mode,
	input  logic [YEAR_W-1:0]        in_year,
	input  logic [MON_W-1:0]         in_month,
	input  logic [DAY_W-1:0]         in_mday,
	input  logic signed [OFF_W-1:0]  in_offset,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic [1:0]               out_status,
	output logic [YEAR_W-1:0]        out_year,
	output logic [MON_W-1:0]         out_month,
	output logic [DAY_W-1:0]         out_mday,
	output logic [1:0]               out_rel,
	output logic signed [DIFF_W-1:0] out_diff
);

	// stored date
	logic [YEAR_W-1:0] cur_year_q;
	logic [MON_W-1:0]  cur_month_q;
	logic [DAY_W-1:0]  cur_mday_q;

	// item in flight
	mode_t                   mode_q;
	logic [YEAR_W-1:0]       gy_q;
	logic [MON_W-1:0]        gm_q;
	logic [DAY_W-1:0]        gd_q;
	logic signed [OFF_W-1:0] off_q;
	status_t                 status_q;
	rel_t                    rel_q;
	logic [DIFF_W-1:0]       diff_q;

	// day-number unit
	logic [YEAR_W-1:0]         y_s1, p_s1;
	logic [MON_W-1:0]          m_s1;
	logic [DAY_W-1:0]          d_s1;
	logic [Q_W-1:0]            q_s1;
	logic [SER_W-1:0]          ser_q, sg_q;
	logic                      leap_q;

	// year search and month walk
	logic [SER_W-1:0]  s_q;
	logic [YEAR_W-1:0] cy_q;
	logic [BIT_W-1:0]  bi_q;
	logic [REM_W-1:0]  r_q;
	logic [MON_W-1:0]  mm_q;

	// output register
	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [YEAR_W-1:0]        out_year_q;
	logic [MON_W-1:0]         out_month_q;
	logic [DAY_W-1:0]         out_mday_q;
	rel_t                     out_rel_q;
	logic [DIFF_W-1:0]        out_diff_q;

	logic [YEAR_W-1:0]         a_y, a_p, cand;
	logic [MON_W-1:0]          a_m;
	logic [DAY_W-1:0]          a_d;
	logic [YEAR_W+RECIP_W-1:0] a_prod;
	logic [Q_W:0]              b_q1;
	logic [Q_W+7:0]            b_hund;
	logic                      b_leap;
	logic [SER_W:0]            b_ser;
	logic                      given_ok;
	logic signed [SUM_W-1:0]   sum;
	logic                      sum_ok;
	logic [DAY_W-1:0]          walk_len;
	logic                      walk_more;
	logic                      out_free;
	rel_t                      cmp_rel;

	assign cand = cy_q | (YEAR_W'(1) << bi_q);

	// select the date fed to the day-number unit
	always_comb begin
		case (cmd.src)
			SRC_GIVEN: begin
				a_y = gy_q;
				a_m = gm_q;
				a_d = gd_q;
			end
			SRC_CUR: begin
				a_y = cur_year_q;
				a_m = cur_month_q;
				a_d = cur_mday_q;
			end
			SRC_CAND: begin
				a_y = cand;
				a_m = MON_W'(1);
				a_d = DAY_W'(1);
			end
			default: begin
				a_y = cy_q;
				a_m = MON_W'(1);
				a_d = DAY_W'(1);
			end
		endcase
		a_p    = a_y - YEAR_W'(1);
		a_prod = (YEAR_W+RECIP_W)'(a_p) * (YEAR_W+RECIP_W)'(RECIP_100);
	end

	// second half: leap rule and day number
	always_comb begin
		b_q1   = {1'b0, q_s1} + (Q_W+1)'(1);
		b_hund = (Q_W+8)'(b_q1) * (Q_W+8)'(100);
		b_leap = (y_s1[1:0] == 2'b00) &&
			((b_hund != (Q_W+8)'(y_s1)) || (b_q1[1:0] == 2'b00));
		b_ser  = (SER_W+1)'(p_s1) * (SER_W+1)'(365)
			+ (SER_W+1)'(p_s1 >> 2)
			- (SER_W+1)'(q_s1)
			+ (SER_W+1)'(q_s1 >> 2)
			+ (SER_W+1)'(days_before(m_s1, b_leap))
			+ (SER_W+1)'(d_s1)
			- (SER_W+1)'(1);
	end

	assign given_ok = (gy_q != '0) && (gm_q >= MON_W'(1)) && (gm_q <= MON_W'(MONTHS))
		&& (gd_q != '0) && (gd_q <= month_len(gm_q, leap_q));

	assign sum    = SUM_W'(signed'({2'b00, ser_q})) + SUM_W'(off_q);
	assign sum_ok = !sum[SUM_W-1] && (sum <= SUM_W'(SER_TOP));

	assign walk_len  = month_len(mm_q, leap_q);
	assign walk_more = (mm_q < MON_W'(MONTHS)) && (r_q >= REM_W'(walk_len));

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		if (cur_year_q != in_year) begin
			cmp_rel = (cur_year_q > in_year) ? REL_GREATER : REL_LESS;
		end else if (cur_month_q != in_month) begin
			cmp_rel = (cur_month_q > in_month) ? REL_GREATER : REL_LESS;
		end else if (cur_mday_q != in_mday) begin
			cmp_rel = (cur_mday_q > in_mday) ? REL_GREATER : REL_LESS;
		end else begin
			cmp_rel = REL_EQUAL;
		end
	end

	assign stat.mode      = mode_q;
	assign stat.sum_ok    = sum_ok;
	assign stat.bit_zero  = (bi_q == '0);
	assign stat.walk_done = !walk_more;
	assign stat.out_free  = out_free;

	// stored date and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q  <= YEAR_W'(1990);
			cur_month_q <= MON_W'(1);
			cur_mday_q  <= DAY_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if ((cmd.op == OP_SET) && given_ok && (gy_q <= YEAR_W'(MAX_YEAR))) begin
				cur_year_q  <= gy_q;
				cur_month_q <= gm_q;
				cur_mday_q  <= gd_q;
			end else if ((cmd.op == OP_WALK) && !walk_more) begin
				cur_year_q  <= cy_q;
				cur_month_q <= mm_q;
				cur_mday_q  <= DAY_W'(r_q) + DAY_W'(1);
			end
			if ((cmd.op == OP_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				mode_q   <= mode_t'(in_mode);
				gy_q     <= in_year;
				gm_q     <= in_month;
				gd_q     <= in_mday;
				off_q    <= in_offset;
				status_q <= ST_OK;
				diff_q   <= '0;
				rel_q    <= ((mode_t'(in_mode) == MODE_CMP) ||
					(mode_t'(in_mode) == MODE_DIFF)) ? cmp_rel : REL_LESS;
			end
			OP_SER_A: begin
				y_s1 <= a_y;
				p_s1 <= a_p;
				m_s1 <= a_m;
				d_s1 <= a_d;
				q_s1 <= a_prod[RECIP_SH +: Q_W];
			end
			OP_SER_B: begin
				ser_q  <= b_ser[SER_W-1:0];
				leap_q <= b_leap;
			end
			OP_SET, OP_SAVE: begin
				if (!given_ok) begin
					status_q <= ST_INVALID;
				end else if (gy_q > YEAR_W'(MAX_YEAR)) begin
					status_q <= ST_RANGE;
				end
				sg_q <= ser_q;
			end
			OP_SUM: begin
				if (sum_ok) begin
					s_q  <= sum[SER_W-1:0];
					cy_q <= '0;
					bi_q <= BIT_W'(YEAR_W - 1);
				end else begin
					status_q <= ST_RANGE;
				end
			end
			OP_SRCH: begin
				// keep the bit if its January 1 is not past the target
				if (ser_q <= s_q) begin
					cy_q <= cand;
				end
				bi_q <= bi_q - BIT_W'(1);
			end
			OP_JAN: begin
				r_q  <= REM_W'(s_q - ser_q);
				mm_q <= MON_W'(1);
			end
			OP_WALK: begin
				if (walk_more) begin
					r_q  <= r_q - REM_W'(walk_len);
					mm_q <= mm_q + MON_W'(1);
				end
			end
			OP_DIFF: begin
				if (status_q == ST_OK) begin
					diff_q <= ser_q - sg_q;
				end
			end
			OP_RESULT: begin
				if (out_free) begin
					out_status_q <= status_q;
					out_year_q   <= cur_year_q;
					out_month_q  <= cur_month_q;
					out_mday_q   <= cur_mday_q;
					out_rel_q    <= rel_q;
					out_diff_q   <= diff_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_year   = out_year_q;
	assign out_month  = out_month_q;
	assign out_mday   = out_mday_q;
	assign out_rel    = out_rel_q;
	assign out_diff   = signed'(out_diff_q);

	`GDA_ASSERT_IMP(a_cur_month, 1'b1, (cur_month_q >= MON_W'(1)) && (cur_month_q <= MON_W'(MONTHS)), "stored month out of range")
	`GDA_ASSERT_NXT(a_walk_commit, (cmd.op == OP_WALK) && !walk_more, (cur_year_q == $past(cy_q)) && (cur_month_q == $past(mm_q)), "month walk did not commit the found date")
	`GDA_ASSERT_NXT(a_range_kept, (cmd.op == OP_SUM) && !sum_ok, $stable(cur_year_q) && $stable(cur_month_q) && (status_q == ST_RANGE), "out-of-range add changed the date")

endmodule

// ===== rtl/gregorian_date_arithmetic_unit.sv =====
// -----------------------------------------------------------------------------
// gregorian_date_arithmetic_unit
// One Gregorian date register with set, add days, compare and difference.
// -----------------------------------------------------------------------------
//  channel   direction  tuser       tdata (lowest bit first)
//  s_axis    in         mode[1:0]   year_in 14, month_in 4, mday_in 5, offset_days 21
//  m_axis    out        -           status 2, year_out 14, month_out 4, mday_out 5,
//                                   relation 2, day_difference 23
//
//  One item at a time. Compare goes straight to the result beat; set and
//  difference pass through the day-number unit; add days finds the year by a
//  14-bit search, one candidate per bit through the shared two-stage
//  day-number unit, then the month walk finds the month and day.
//  Reset loads 1990-01-01 and empties the output register.
//  A stalled result beat holds in the output register; the next item is taken
//  meanwhile and waits at the end of its work until that register frees.
// -----------------------------------------------------------------------------
module gregorian_date_arithmetic_unit import gda_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // year_in, month_in, mday_in, offset_days, zero fill
	input  logic [1:0]  s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata   // status, year_out, month_out, mday_out, relation,
	                                   // day_difference, zero fill
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     item_ready;

	logic [1:0]               o_status;
	logic [YEAR_W-1:0]        o_year;
	logic [MON_W-1:0]         o_month;
	logic [DAY_W-1:0]         o_mday;
	logic [1:0]               o_rel;
	logic signed [DIFF_W-1:0] o_diff;

	assign s_axis_tready = item_ready;

	// sequencer: one state per datapath step
	gda_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_axis_tvalid),
		.item_mode  (s_axis_tuser),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// unpack the input beat straight into the datapath; it captures on load
	gda_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_mode    (s_axis_tuser),
		.in_year    (s_axis_tdata[13:0]),
		.in_month   (s_axis_tdata[17:14]),
		.in_mday    (s_axis_tdata[22:18]),
		.in_offset  (signed'(s_axis_tdata[43:23])),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_status (o_status),
		.out_year   (o_year),
		.out_month  (o_month),
		.out_mday   (o_mday),
		.out_rel    (o_rel),
		.out_diff   (o_diff)
	);

	// pack the result beat, zero fill to whole bytes
	assign m_axis_tdata = {6'd0, o_diff, o_rel, o_mday, o_month, o_year, o_status};

endmodule

// ===== dv/gregorian_date_arithmetic_unit_tb.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// gregorian_date_arithmetic_unit_tb
// Drives set, add-days, compare and difference requests into the date unit and
// checks every result beat against a calendar predictor kept in the bench.
// -----------------------------------------------------------------------------

// Calendar predictor plus queue of pending result beats.
class date_ledger;
	logic [13:0] yr;
	logic [3:0]  mo;
	logic [4:0]  dy;
	logic [55:0] pending[$];
	int          errors;
	int          checked;

	function new();
		yr = 14'd1990;
		mo = 4'd1;
		dy = 5'd1;
		errors = 0;
		checked = 0;
	endfunction

	function bit leap(int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function int mlen(int y, int m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11: return 30;
			2: return leap(y) ? 29 : 28;
			default: return 0;
		endcase
	endfunction

	function bit valid(int y, int m, int d);
		return y > 0 && m >= 1 && m <= 12 && d >= 1 && d <= mlen(y, m);
	endfunction

	function longint day_number(int y, int m, int d);
		longint p;
		longint s;
		p = y - 1;
		s = p * 365 + p / 4 - p / 100 + p / 400;
		for (int k = 1; k < m; k++) s += mlen(y, k);
		return s + d - 1;
	endfunction

	function void from_day_number(longint s);
		longint n400;
		longint r;
		longint n100;
		longint n4;
		longint n1;
		int y;
		int m;
		n400 = s / 146097;
		r = s % 146097;
		n100 = r / 36524;
		if (n100 == 4) n100 = 3;
		r -= n100 * 36524;
		n4 = r / 1461;
		r %= 1461;
		n1 = r / 365;
		if (n1 == 4) n1 = 3;
		r -= n1 * 365;
		y = 400 * n400 + 100 * n100 + 4 * n4 + n1 + 1;
		m = 1;
		while (m < 12 && r >= mlen(y, m)) begin
			r -= mlen(y, m);
			m++;
		end
		yr = 14'(y);
		mo = 4'(m);
		dy = 5'(r + 1);
	endfunction

	// Advance the calendar state for one accepted request and queue its beat.
	function void note_request(gda_pkg::mode_t mode, logic [47:0] data);
		int gy;
		int gm;
		int gd;
		longint off;
		longint s;
		logic [1:0] st;
		logic [1:0] rel;
		logic [22:0] diff;
		gy = data[13:0];
		gm = data[17:14];
		gd = data[22:18];
		off = longint'($signed(data[43:23]));
		st = gda_pkg::ST_OK;
		rel = gda_pkg::REL_LESS;
		diff = '0;
		case (mode)
			gda_pkg::MODE_SET: begin
				if (!valid(gy, gm, gd)) st = gda_pkg::ST_INVALID;
				else if (gy > gda_pkg::MAX_YEAR) st = gda_pkg::ST_RANGE;
				else begin
					yr = 14'(gy);
					mo = 4'(gm);
					dy = 5'(gd);
				end
			end
			gda_pkg::MODE_ADD: begin
				s = day_number(yr, mo, dy) + off;
				if (s < 0 || s > day_number(gda_pkg::MAX_YEAR, 12, 31))
					st = gda_pkg::ST_RANGE;
				else from_day_number(s);
			end
			default: begin
				if (yr != gy) rel = yr > gy ? gda_pkg::REL_GREATER : gda_pkg::REL_LESS;
				else if (mo != gm) rel = mo > gm ? gda_pkg::REL_GREATER : gda_pkg::REL_LESS;
				else if (dy != gd) rel = dy > gd ? gda_pkg::REL_GREATER : gda_pkg::REL_LESS;
				else rel = gda_pkg::REL_EQUAL;
				if (mode == gda_pkg::MODE_DIFF) begin
					if (!valid(gy, gm, gd)) st = gda_pkg::ST_INVALID;
					else if (gy > gda_pkg::MAX_YEAR) st = gda_pkg::ST_RANGE;
					else diff = 23'(day_number(yr, mo, dy) - day_number(gy, gm, gd));
				end
			end
		endcase
		pending.push_back({6'd0, diff, rel, dy, mo, yr, st});
	endfunction

	function void check_result(logic [55:0] got);
		logic [55:0] exp;
		if (pending.size() == 0) begin
			$error("result beat with nothing expected: %h", got);
			errors++;
			return;
		end
		exp = pending.pop_front();
		checked++;
		if (got[1:0] !== exp[1:0]) begin
			$error("status: expected %0d, got %0d", exp[1:0], got[1:0]);
			errors++;
		end
		if (got[15:2] !== exp[15:2]) begin
			$error("year_out: expected %0d, got %0d", exp[15:2], got[15:2]);
			errors++;
		end
		if (got[19:16] !== exp[19:16]) begin
			$error("month_out: expected %0d, got %0d", exp[19:16], got[19:16]);
			errors++;
		end
		if (got[24:20] !== exp[24:20]) begin
			$error("mday_out: expected %0d, got %0d", exp[24:20], got[24:20]);
			errors++;
		end
		if (got[26:25] !== exp[26:25]) begin
			$error("relation: expected %0d, got %0d", exp[26:25], got[26:25]);
			errors++;
		end
		if (got[49:27] !== exp[49:27]) begin
			$error("day_difference: expected %0d, got %0d",
				$signed(exp[49:27]), $signed(got[49:27]));
			errors++;
		end
	endfunction
endclass

module gregorian_date_arithmetic_unit_tb;
	import gda_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // year_in, month_in, mday_in, offset_days, zero fill
	logic [1:0]  s_axis_tuser;   // mode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;   // status, year_out, month_out, mday_out, relation,
	                             // day_difference, zero fill

	date_ledger ledger;
	int         send_idle_pct;   // percent of cycles the sender skips
	int         recv_idle_pct;   // percent of cycles the receiver stalls
	bit         hold_off;        // long receiver stall in progress
	int         idle_cycles;
	int         n_sent;

	gregorian_date_arithmetic_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver: stall at random, or hard during a hold-off; check each accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) ledger.check_result(m_axis_tdata);
			m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: count cycles without any accepted beat on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", idle_cycles);
			$display("TEST FAILED");
			$finish;
		end else idle_cycles <= idle_cycles + 1;
	end

	// Offer one request, idling at random first, and hold it until accepted.
	// tvalid stays high after the accept; the next request replaces or drops it, or drain() drops it.
	task automatic send(mode_t mode, int y, int m, int d, int off);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {4'd0, 21'(off), 5'(d), 4'(m), 14'(y)};
		do @(posedge clk); while (!s_axis_tready);
		ledger.note_request(mode, {4'd0, 21'(off), 5'(d), 4'(m), 14'(y)});
		n_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (ledger.pending.size() != 0) @(posedge clk);
	endtask

	// Mostly valid dates, sometimes random junk in every field.
	task automatic send_random();
		int y;
		int m;
		int d;
		int off;
		mode_t mode;
		mode = mode_t'($urandom_range(3));
		if ($urandom_range(9) < 8) begin
			y = ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(9999, 1);
			m = $urandom_range(12, 1);
			d = $urandom_range(ledger.mlen(y, m), 1);
		end else begin
			y = $urandom_range(16383);
			m = $urandom_range(15);
			d = $urandom_range(31);
		end
		case ($urandom_range(3))
			0: off = $urandom_range(800) - 400;
			1: off = $urandom_range(80000) - 40000;
			default: off = int'($signed(21'($urandom)));
		endcase
		send(mode, y, m, d, off);
	endtask

	initial begin
		ledger = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_SET;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		idle_cycles = 0;
		n_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset date, invalid sets, leap days, range edges, compare rules.
		send(MODE_CMP, 1990, 1, 1, 0);
		send(MODE_DIFF, 1, 1, 1, 0);
		send(MODE_SET, 0, 1, 1, 0);
		send(MODE_SET, 2023, 13, 1, 0);
		send(MODE_SET, 2023, 0, 1, 0);
		send(MODE_SET, 2023, 4, 31, 0);
		send(MODE_SET, 1900, 2, 29, 0);
		send(MODE_SET, 2000, 2, 29, 0);
		send(MODE_ADD, 0, 0, 0, 1);
		send(MODE_ADD, 0, 0, 0, -1);
		send(MODE_SET, 10000, 1, 1, 0);
		send(MODE_SET, 16383, 15, 31, 0);
		send(MODE_SET, 1, 1, 1, 0);
		send(MODE_ADD, 0, 0, 0, -1);
		send(MODE_ADD, 0, 0, 0, 1048575);
		send(MODE_ADD, 0, 0, 0, -1048576);
		send(MODE_SET, 9999, 12, 31, 0);
		send(MODE_ADD, 0, 0, 0, 1);
		send(MODE_DIFF, 1, 1, 1, 0);
		send(MODE_DIFF, 9999, 12, 31, 0);
		send(MODE_DIFF, 2001, 2, 29, 0);
		send(MODE_DIFF, 10000, 1, 1, 0);
		send(MODE_CMP, 9998, 12, 31, 0);
		send(MODE_CMP, 16383, 0, 0, 0);
		send(MODE_CMP, 9999, 11, 31, 0);
		drain();

		// Random phase one: light sender idling, heavy receiver stalls.
		send_idle_pct = 18;
		recv_idle_pct = 87;
		repeat (600) send_random();

		// Long receiver hold-off while the sender keeps offering.
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				repeat (20) send_random();
				drain();
			end
		join

		// Random phase two: roles swapped.
		send_idle_pct = 87;
		recv_idle_pct = 18;
		repeat (600) send_random();
		drain();

		// Random phase three: full throughput.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (650) send_random();
		drain();
		repeat (100) @(posedge clk);

		$display("Run covered %0d requests over all four modes, %0d result beats checked.",
			n_sent, ledger.checked);
		if (ledger.errors == 0 && ledger.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
